// ----- rtl/core/bounded_lifo_stack_unit_macros.svh -----
// Assertion macros used by the checker file of the stack unit.
`ifndef BOUNDED_LIFO_STACK_UNIT_MACROS_SVH
`define BOUNDED_LIFO_STACK_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLSU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BLSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/blsu_pkg.sv -----
// Package with the types, codes and defaults of the bounded stack unit.
package blsu_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int WORD_BITS_DEF = 32;
  localparam int DATA_BITS     = 32;
  localparam int CAP_BITS      = 7;
  localparam int LEVEL_BITS    = 7;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

  typedef enum logic [3:0] {
    OP_PUSH        = 4'd0,
    OP_POP         = 4'd1,
    OP_POP_ZERO    = 4'd2,
    OP_POP_OR_TOP  = 4'd3,
    OP_DUP         = 4'd4,
    OP_DROP        = 4'd5,
    OP_DROP_N      = 4'd6,
    OP_PICK        = 4'd7,
    OP_PICK_BOTTOM = 4'd8,
    OP_SET_TOP     = 4'd9,
    OP_SET_BOTTOM  = 4'd10
  } stack_op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_UNDER = 2'd1,
    STAT_OVER  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DROP,
    S_SEEK,
    S_RETURN
  } ctrl_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_UP,
    CELL_DOWN
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     load;
  } cell_ctrl_t;

  typedef struct packed {
    logic [3:0]                  op;
    logic signed [DATA_BITS-1:0] value;
    logic [5:0]                  offset;
    logic [6:0]                  drop_count;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] data;
    logic [LEVEL_BITS-1:0]       depth;
    logic [1:0]                  status;
  } out_item_t;

endpackage

// ----- rtl/core/blsu_cell.sv -----
// One stack cell: holds a word, loads a new one, or shifts it towards either neighbour.
module blsu_cell #(
  parameter int WORD_BITS = blsu_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  blsu_pkg::cell_ctrl_t ctrl,
  input  logic [WORD_BITS-1:0] up_word,
  input  logic [WORD_BITS-1:0] down_word,
  input  logic [WORD_BITS-1:0] load_word,
  output logic [WORD_BITS-1:0] word
);
  import blsu_pkg::*;

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctrl.load) begin
      word_nxt = load_word;
    end else begin
      case (ctrl.op)
        CELL_UP:   word_nxt = up_word;
        CELL_DOWN: word_nxt = down_word;
        default:   word_nxt = word_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// ----- rtl/core/blsu_outbuf.sv -----
// Two-entry result buffer between the sequencer and the output channel.
module blsu_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  blsu_pkg::out_item_t res,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output blsu_pkg::out_item_t out_item
);
  import blsu_pkg::*;

  logic [1:0] fill_r;
  logic [1:0] fill_nxt;
  out_item_t  head_r;
  out_item_t  head_nxt;
  out_item_t  skid_r;
  out_item_t  skid_nxt;
  logic       take;

  assign out_valid = (fill_r != 2'd0);
  assign out_item  = head_r;
  assign room      = (fill_r != 2'd2);
  assign take      = out_valid && !out_stall;

  always_comb begin
    fill_nxt = fill_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    if (take && res_valid) begin
      if (fill_r == 2'd1) begin
        head_nxt = res;
      end else begin
        head_nxt = skid_r;
        skid_nxt = res;
      end
    end else if (take) begin
      head_nxt = skid_r;
      fill_nxt = fill_r - 2'd1;
    end else if (res_valid) begin
      if (fill_r == 2'd0) begin
        head_nxt = res;
      end else begin
        skid_nxt = res;
      end
      fill_nxt = fill_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ----- rtl/core/blsu_ctrl.sv -----
// Sequencer: decodes each item, drives the cell row and forms the result.
module blsu_ctrl #(
  parameter int DEPTH     = blsu_pkg::DEPTH_DEF,
  parameter int WORD_BITS = blsu_pkg::WORD_BITS_DEF,
  localparam int IDX_W    = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  blsu_pkg::in_item_t                in_item,
  input  logic                              cfg_wr_en,
  input  logic [blsu_pkg::CAP_BITS-1:0]     cfg_wr_data,
  input  logic [WORD_BITS-1:0]              top_word,
  input  logic [WORD_BITS-1:0]              second_word,
  input  logic [WORD_BITS-1:0]              last_word,
  input  logic                              buf_room,
  output blsu_pkg::cell_ctrl_t              cmd,
  output logic [IDX_W-1:0]                  load_idx,
  output logic [WORD_BITS-1:0]              load_word,
  output logic [WORD_BITS-1:0]              fill_word,
  output logic                              res_valid,
  output blsu_pkg::out_item_t               res
);
  import blsu_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

  ctrl_state_t          state_r;
  ctrl_state_t          state_nxt;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     rem_nxt;
  logic [CNT_W-1:0]     steps_r;
  logic [CNT_W-1:0]     steps_nxt;
  logic [CAP_BITS-1:0]  cap_r;

  logic                 accept;
  logic [WORD_BITS-1:0] val_w;
  logic [CMP_W-1:0]     n_ext;
  logic [CMP_W-1:0]     cap_ext;
  logic [CMP_W-1:0]     cap_eff;
  logic [CMP_W-1:0]     off_ext;
  logic [CMP_W-1:0]     cnt_ext;
  logic                 empty;
  logic                 at_cap;
  logic                 off_ok;
  logic                 cnt_ok;
  logic                 is_pick;
  logic [WORD_BITS-1:0] res_word;
  status_t              res_status;

  assign in_stall = (state_r != S_IDLE) || !buf_room;
  assign accept   = in_valid && !in_stall;
  assign val_w    = WORD_BITS'(in_item.value);

  always_comb begin
    n_ext   = CMP_W'(count_r);
    cap_ext = CMP_W'(cap_r);
    off_ext = CMP_W'(in_item.offset);
    cnt_ext = CMP_W'(in_item.drop_count);
    if (cap_r == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      cap_eff = CMP_W'(DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
    empty   = (count_r == '0);
    at_cap  = (n_ext >= cap_eff);
    off_ok  = (off_ext < n_ext);
    cnt_ok  = (cnt_ext <= n_ext);
    is_pick = (in_item.op == OP_PICK) || (in_item.op == OP_PICK_BOTTOM);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if ((in_item.op == OP_DROP_N) && cnt_ok) begin
            state_nxt = S_DROP;
          end else if (is_pick && off_ok) begin
            state_nxt = S_SEEK;
          end
        end
      end
      S_DROP: begin
        if (rem_r == '0) begin
          state_nxt = S_IDLE;
        end
      end
      S_SEEK: begin
        if (rem_r == '0) begin
          state_nxt = (steps_r == '0) ? S_IDLE : S_RETURN;
        end
      end
      S_RETURN: begin
        if (rem_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '{op: CELL_HOLD, load: 1'b0};
    load_idx   = '0;
    load_word  = val_w;
    fill_word  = val_w;
    res_valid  = 1'b0;
    res_word   = '0;
    res_status = STAT_OK;
    count_nxt  = count_r;
    rem_nxt    = rem_r;
    steps_nxt  = steps_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_valid = 1'b1;
          case (in_item.op)
            OP_PUSH: begin
              if (at_cap) begin
                res_status = STAT_OVER;
              end else begin
                cmd.op    = CELL_DOWN;
                count_nxt = count_r + CNT_W'(1);
                res_word  = val_w;
              end
            end
            OP_POP: begin
              if (empty) begin
                res_status = STAT_UNDER;
              end else begin
                cmd.op    = CELL_UP;
                count_nxt = count_r - CNT_W'(1);
                res_word  = top_word;
              end
            end
            OP_POP_ZERO: begin
              if (!empty) begin
                cmd.op    = CELL_UP;
                count_nxt = count_r - CNT_W'(1);
                res_word  = top_word;
              end
            end
            OP_POP_OR_TOP: begin
              if (empty) begin
                res_status = STAT_UNDER;
              end else begin
                res_word = top_word;
                if (count_r > CNT_W'(1)) begin
                  cmd.op    = CELL_UP;
                  count_nxt = count_r - CNT_W'(1);
                end
              end
            end
            OP_DUP: begin
              if (empty) begin
                res_status = STAT_UNDER;
              end else if (at_cap) begin
                res_status = STAT_OVER;
              end else begin
                cmd.op    = CELL_DOWN;
                fill_word = top_word;
                count_nxt = count_r + CNT_W'(1);
                res_word  = top_word;
              end
            end
            OP_DROP: begin
              if (empty) begin
                res_status = STAT_UNDER;
              end else begin
                cmd.op    = CELL_UP;
                count_nxt = count_r - CNT_W'(1);
                res_word  = (count_r > CNT_W'(1)) ? second_word : '0;
              end
            end
            OP_DROP_N: begin
              if (!cnt_ok) begin
                res_status = STAT_UNDER;
              end else begin
                res_valid = 1'b0;
                count_nxt = CNT_W'(n_ext - cnt_ext);
                rem_nxt   = CNT_W'(cnt_ext);
              end
            end
            OP_PICK: begin
              if (!off_ok) begin
                res_status = STAT_RANGE;
              end else begin
                res_valid = 1'b0;
                rem_nxt   = CNT_W'(off_ext);
                steps_nxt = CNT_W'(off_ext);
              end
            end
            OP_PICK_BOTTOM: begin
              if (!off_ok) begin
                res_status = STAT_RANGE;
              end else begin
                res_valid = 1'b0;
                rem_nxt   = CNT_W'(n_ext - off_ext - CMP_W'(1));
                steps_nxt = CNT_W'(n_ext - off_ext - CMP_W'(1));
              end
            end
            OP_SET_TOP: begin
              if (empty) begin
                res_status = STAT_UNDER;
              end else begin
                cmd.load = 1'b1;
                load_idx = '0;
                res_word = val_w;
              end
            end
            OP_SET_BOTTOM: begin
              if (empty) begin
                res_status = STAT_UNDER;
              end else begin
                cmd.load = 1'b1;
                load_idx = IDX_W'(count_r - CNT_W'(1));
                res_word = val_w;
              end
            end
            default: begin
              res_status = STAT_OK;
            end
          endcase
        end
      end
      S_DROP: begin
        if (rem_r != '0) begin
          cmd.op  = CELL_UP;
          rem_nxt = rem_r - CNT_W'(1);
        end else begin
          res_valid = 1'b1;
          res_word  = (count_r != '0) ? top_word : '0;
        end
      end
      S_SEEK: begin
        if (rem_r != '0) begin
          cmd.op  = CELL_UP;
          rem_nxt = rem_r - CNT_W'(1);
        end else begin
          res_valid = 1'b1;
          res_word  = top_word;
          rem_nxt   = steps_r;
        end
      end
      S_RETURN: begin
        cmd.op    = CELL_DOWN;
        fill_word = last_word;
        rem_nxt   = rem_r - CNT_W'(1);
      end
      default: begin
        cmd.op = CELL_HOLD;
      end
    endcase
  end

  always_comb begin
    res.data   = DATA_BITS'(res_word);
    res.depth  = LEVEL_BITS'(count_nxt);
    res.status = res_status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      rem_r   <= '0;
      steps_r <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      steps_r <= steps_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

endmodule

// ----- rtl/core/bounded_lifo_stack_unit.sv -----
// Top level of the bounded stack unit: sequencer, row of cells and result buffer.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   in_item  (op, value, offset, drop_count)
//   out_     output     out_valid / out_stall out_item (data, depth, status)
//   cfg_     input      cfg_wr_en             cfg_wr_data (capacity)
//
// Cell 0 holds the top of the stack; all cells shift to their neighbours together.
// Most operations complete on acceptance; drop_n shifts the row up by its count, then
// returns the new top. A pick at distance k from the top rotates the row k places
// up to bring the entry to cell 0 and then k places back down.
// Reset empties the stack and sets the capacity to 64; cell contents are not cleared.
// A new item is taken once the sequencer is idle and the two-entry result buffer has room.
module bounded_lifo_stack_unit #(
  parameter int DEPTH     = blsu_pkg::DEPTH_DEF,
  parameter int WORD_BITS = blsu_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  blsu_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output blsu_pkg::out_item_t           out_item,
  input  logic                          cfg_wr_en,
  input  logic [blsu_pkg::CAP_BITS-1:0] cfg_wr_data
);
  import blsu_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  logic [WORD_BITS-1:0] words [DEPTH];
  cell_ctrl_t           cmd;
  logic [IDX_W-1:0]     load_idx;
  logic [WORD_BITS-1:0] load_word;
  logic [WORD_BITS-1:0] fill_word;
  logic                 res_valid;
  out_item_t            res;
  logic                 buf_room;

  blsu_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .top_word    (words[0]),
    .second_word (words[1]),
    .last_word   (words[DEPTH-1]),
    .buf_room    (buf_room),
    .cmd         (cmd),
    .load_idx    (load_idx),
    .load_word   (load_word),
    .fill_word   (fill_word),
    .res_valid   (res_valid),
    .res         (res)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t           cell_ctrl;
    logic [WORD_BITS-1:0] up_word;
    logic [WORD_BITS-1:0] down_word;

    assign cell_ctrl.op   = cmd.op;
    assign cell_ctrl.load = cmd.load && (load_idx == IDX_W'(i));
    assign up_word        = words[(i + 1) % DEPTH];
    if (i == 0) begin : g_head
      assign down_word = fill_word;
    end else begin : g_body
      assign down_word = words[i-1];
    end

    blsu_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .up_word   (up_word),
      .down_word (down_word),
      .load_word (load_word),
      .word      (words[i])
    );
  end

  blsu_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .room      (buf_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- rtl/core/blsu_checker.sv -----
// Port checker for the bounded stack unit, with its bind to the top level.
`include "bounded_lifo_stack_unit_macros.svh"

module blsu_checker #(
  parameter int DEPTH = blsu_pkg::DEPTH_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input blsu_pkg::out_item_t out_item
);
  import blsu_pkg::*;

  `BLSU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result item changed")
  `BLSU_ASSERT_SAME(a_depth_max, out_valid, out_item.depth <= DEPTH, "result depth beyond the stack size")
  `BLSU_ASSERT_SAME(a_err_zero, out_valid && (out_item.status != STAT_OK), out_item.data == '0, "failed operation returned data")
  `BLSU_ASSERT_SAME(a_over_depth, out_valid && (out_item.status == STAT_OVER), out_item.depth != '0, "overflow reported on an empty stack")

endmodule

bind bounded_lifo_stack_unit blsu_checker #(.DEPTH(DEPTH)) u_checker (.*);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the bounded stack unit: directed and random ops, gaps and stalls.
`timescale 1ns / 1ps

module tb_top;
  import blsu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int STACK_SLOTS = DEPTH_DEF;
  localparam logic [3:0] OP_FIRST_UNUSED = 4'd11;
  localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                cfg_wr_en = 1'b0;
  logic [CAP_BITS-1:0] cfg_wr_data = '0;

  in_item_t    op_queue[$];
  out_item_t   expected_results[$];
  logic signed [DATA_BITS-1:0] stack_words[STACK_SLOTS];
  int          stack_level;
  int          capacity_setting;
  logic        in_taken = 1'b0;
  bit          steady_sender = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_hold = 0;
  int          cycle_count = 0;
  int          fail_count = 0;
  int          ops_applied = 0;
  int          results_checked = 0;
  int          settings_used = 0;

  bounded_lifo_stack_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic predict_stack_op(input in_item_t item, output out_item_t result);
    int                          depth_now;
    int                          limit;
    status_t                     status;
    logic signed [DATA_BITS-1:0] word;
    depth_now = stack_level;
    limit = (capacity_setting == 0) ? 1 :
            (capacity_setting > STACK_SLOTS) ? STACK_SLOTS : capacity_setting;
    status = STAT_OK;
    word = '0;
    case (item.op)
      OP_PUSH: begin
        if (depth_now >= limit) begin
          status = STAT_OVER;
        end else begin
          stack_words[depth_now] = item.value;
          stack_level = depth_now + 1;
          word = item.value;
        end
      end
      OP_POP: begin
        if (depth_now == 0) begin
          status = STAT_UNDER;
        end else begin
          word = stack_words[depth_now - 1];
          stack_level = depth_now - 1;
        end
      end
      OP_POP_ZERO: begin
        if (depth_now != 0) begin
          word = stack_words[depth_now - 1];
          stack_level = depth_now - 1;
        end
      end
      OP_POP_OR_TOP: begin
        if (depth_now == 0) begin
          status = STAT_UNDER;
        end else begin
          word = stack_words[depth_now - 1];
          if (depth_now > 1) stack_level = depth_now - 1;
        end
      end
      OP_DUP: begin
        if (depth_now == 0) begin
          status = STAT_UNDER;
        end else if (depth_now >= limit) begin
          status = STAT_OVER;
        end else begin
          word = stack_words[depth_now - 1];
          stack_words[depth_now] = word;
          stack_level = depth_now + 1;
        end
      end
      OP_DROP: begin
        if (depth_now == 0) begin
          status = STAT_UNDER;
        end else begin
          stack_level = depth_now - 1;
          if (stack_level != 0) word = stack_words[stack_level - 1];
        end
      end
      OP_DROP_N: begin
        if (int'(item.drop_count) > depth_now) begin
          status = STAT_UNDER;
        end else begin
          stack_level = depth_now - int'(item.drop_count);
          if (stack_level != 0) word = stack_words[stack_level - 1];
        end
      end
      OP_PICK: begin
        if (int'(item.offset) >= depth_now) begin
          status = STAT_RANGE;
        end else begin
          word = stack_words[depth_now - 1 - int'(item.offset)];
        end
      end
      OP_PICK_BOTTOM: begin
        if (int'(item.offset) >= depth_now) begin
          status = STAT_RANGE;
        end else begin
          word = stack_words[item.offset];
        end
      end
      OP_SET_TOP: begin
        if (depth_now == 0) begin
          status = STAT_UNDER;
        end else begin
          stack_words[depth_now - 1] = item.value;
          word = item.value;
        end
      end
      OP_SET_BOTTOM: begin
        if (depth_now == 0) begin
          status = STAT_UNDER;
        end else begin
          stack_words[0] = item.value;
          word = item.value;
        end
      end
      default: begin
      end
    endcase
    result.data = word;
    result.depth = stack_level[LEVEL_BITS-1:0];
    result.status = status;
  endtask

  always @(posedge clk) begin : monitor
    out_item_t expected;
    out_item_t predicted;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("bounded_lifo_stack_unit: mismatch");
      $finish;
    end else if (!rst_n) begin
      stack_level = 0;
      capacity_setting = int'(CAP_RESET);
      in_taken <= 1'b0;
    end else begin
      if (cfg_wr_en) capacity_setting = int'(cfg_wr_data);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no item waiting: data %0d depth %0d status %0d",
                 out_item.data, out_item.depth, out_item.status);
          fail_count++;
        end else begin
          expected = expected_results.pop_front();
          results_checked++;
          if (out_item.data !== expected.data) begin
            $error("data: expected %0d, actual %0d", expected.data, out_item.data);
            fail_count++;
          end
          if (out_item.depth !== expected.depth) begin
            $error("depth: expected %0d, actual %0d", expected.depth, out_item.depth);
            fail_count++;
          end
          if (out_item.status !== expected.status) begin
            $error("status: expected %0d, actual %0d", expected.status, out_item.status);
            fail_count++;
          end
        end
      end
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_stack_op(in_item, predicted);
        expected_results.push_back(predicted);
        void'(op_queue.pop_front());
        ops_applied++;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (op_queue.size() > 0) begin
      in_valid <= 1'b1;
      in_item <= op_queue[0];
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(12, 1);
        if (steady_sender || $urandom_range(3, 0) == 0) gap_left <= 0;
        else gap_left <= $urandom_range(6, 1);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (stall_hold == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(STALL_TOGGLE, STALL_NONE));
      stall_hold <= $urandom_range(80, 20);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(3, 0) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(3, 0) != 0);
      default:     out_stall <= ~out_stall;
    endcase
  end

  task automatic queue_op(input logic [3:0] op, input logic [31:0] value,
                          input logic [5:0] offset, input logic [6:0] count);
    in_item_t item;
    item.op = op;
    item.value = value;
    item.offset = offset;
    item.drop_count = count;
    op_queue.push_back(item);
  endtask

  task automatic queue_random_ops(input int count, input int fill_pct);
    logic [3:0]  op;
    logic [31:0] value;
    logic [5:0]  offset;
    logic [6:0]  drop;
    int          roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99, 0);
      if (roll < 3) op = 4'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
      else if (roll < 3 + fill_pct) op = OP_PUSH;
      else op = 4'($urandom_range(OP_SET_BOTTOM, OP_POP));
      case ($urandom_range(9, 0))
        0: value = 32'h7FFF_FFFF;
        1: value = 32'h8000_0000;
        2: value = 32'hFFFF_FFFF;
        default: value = $urandom;
      endcase
      offset = ($urandom_range(3, 0) != 0) ? 6'($urandom_range(5, 0)) :
               6'($urandom_range(63, 0));
      drop = ($urandom_range(4, 0) != 0) ? 7'($urandom_range(3, 0)) :
             7'($urandom_range(127, 0));
      queue_op(op, value, offset, drop);
    end
  endtask

  task automatic wait_drained();
    while (op_queue.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_BITS-1:0] cap);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every operation on an empty stack first, then a small stack at the extremes.
    queue_op(OP_POP, '0, '0, '0);
    queue_op(OP_POP_ZERO, '0, '0, '0);
    queue_op(OP_POP_OR_TOP, '0, '0, '0);
    queue_op(OP_DUP, '0, '0, '0);
    queue_op(OP_DROP, '0, '0, '0);
    queue_op(OP_DROP_N, '0, '0, 7'd0);
    queue_op(OP_DROP_N, '0, '0, 7'd1);
    queue_op(OP_PICK, '0, 6'd0, '0);
    queue_op(OP_PICK_BOTTOM, '0, 6'd0, '0);
    queue_op(OP_SET_TOP, 32'h1111_1111, '0, '0);
    queue_op(OP_SET_BOTTOM, 32'h2222_2222, '0, '0);
    queue_op(OP_PUSH, 32'h7FFF_FFFF, '0, '0);
    queue_op(OP_POP_OR_TOP, '0, '0, '0);
    queue_op(OP_PUSH, 32'h8000_0000, '0, '0);
    queue_op(OP_PUSH, 32'hFFFF_FFFF, '0, '0);
    queue_op(OP_DUP, '0, '0, '0);
    queue_op(OP_PUSH, 32'h0000_0000, '0, '0);
    queue_op(OP_PICK, '0, 6'd4, '0);
    queue_op(OP_PICK, '0, 6'd63, '0);
    queue_op(OP_PICK_BOTTOM, '0, 6'd0, '0);
    queue_op(OP_SET_TOP, 32'h1234_5678, '0, '0);
    queue_op(OP_SET_BOTTOM, 32'hA5A5_A5A5, '0, '0);
    queue_op(OP_DROP_N, '0, '0, 7'd64);
    queue_op(OP_DROP_N, '0, '0, 7'd2);
    queue_op(OP_DROP, '0, '0, '0);
    queue_op(OP_POP, '0, '0, '0);
    queue_op(OP_POP_ZERO, '0, '0, '0);
    queue_op(OP_LAST_UNUSED, 32'hFFFF_FFFF, 6'd63, 7'd127);
    wait_drained();

    set_capacity(7'd127);
    queue_random_ops(100, 70);
    wait_drained();

    set_capacity(7'd3);
    queue_random_ops(60, 30);
    wait_drained();

    set_capacity(7'd0);
    queue_random_ops(50, 45);
    wait_drained();

    set_capacity(7'd1);
    queue_random_ops(40, 50);
    wait_drained();

    steady_sender = 1'b1;
    set_capacity(7'd64);
    queue_random_ops(100, 55);
    wait_drained();
    steady_sender = 1'b0;

    set_capacity(7'($urandom_range(64, 1)));
    queue_random_ops(60, 50);
    wait_drained();

    repeat (150) @(posedge clk);
    $display("Applied %0d stack operations under %0d capacity settings after reset,",
             ops_applied, settings_used);
    $display("and compared %0d results in %0d cycles.", results_checked, cycle_count);
    if (fail_count == 0) begin
      $display("bounded_lifo_stack_unit: match");
    end else begin
      $display("bounded_lifo_stack_unit: mismatch");
    end
    $finish;
  end

endmodule
